// ===== rtl/core/rsnh_pkg.sv =====
// shared types and constants for the ray / sphere nearest-hit block
`timescale 1ns / 1ps
`default_nettype none
package rsnh_pkg;

  // fixed point format of coordinates and direction
  localparam int FRAC_BITS  = 16;
  localparam int CFG_W      = 21;
  localparam int ROOT_ITERS = 21;
  localparam int CNT_W      = 5;

  // configuration register indexes
  localparam logic CFG_SPHERE_RADIUS = 1'b0;
  localparam logic CFG_BODY_HEIGHT   = 1'b1;

  localparam logic [CFG_W-1:0] RADIUS_RST = 21'd32768;
  localparam logic [CFG_W-1:0] HEIGHT_RST = 21'd117965;

  // request kinds
  localparam logic REQ_RAY    = 1'b0;
  localparam logic REQ_TARGET = 1'b1;

  typedef enum logic [2:0] {
    ZONE_HEAD    = 3'd0,
    ZONE_CHEST   = 3'd1,
    ZONE_STOMACH = 3'd2,
    ZONE_L_ARM   = 3'd3,
    ZONE_R_ARM   = 3'd4,
    ZONE_L_LEG   = 3'd5,
    ZONE_R_LEG   = 3'd6
  } zone_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD_RAY,
    OP_LOAD_TGT,
    OP_SUB,
    OP_DOT,
    OP_P,
    OP_V,
    OP_SQ,
    OP_R2,
    OP_ROOT,
    OP_T,
    OP_HP,
    OP_COMMIT,
    OP_OUT
  } dp_op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SUB,
    ST_DOT,
    ST_P,
    ST_V,
    ST_SQ,
    ST_R2,
    ST_ROOT,
    ST_T,
    ST_HP,
    ST_COMMIT,
    ST_ZONE
  } state_t;

  typedef struct packed {
    dp_op_t     op;
    logic [1:0] idx;
  } dp_cmd_t;

  typedef struct packed {
    logic cand_ok;  // candidate id is neither zero nor the shooter
    logic v_out;    // closest approach component beyond radius
    logic r2_neg;   // closest approach beyond radius
    logic t_bad;    // hit distance negative or farther than current
  } dp_status_t;

endpackage
`default_nettype wire

// ===== rtl/core/rsnh_ctrl.sv =====
// sequencer for the intersection steps and the result handshake
`timescale 1ns / 1ps
`default_nettype none
module rsnh_ctrl (
  input  wire                  clk,
  input  wire                  rst_n,
  input  wire                  in_valid,
  output logic                 in_ready,
  input  wire                  in_req_type,
  input  wire                  in_last,
  output logic                 out_valid,
  input  wire                  out_ready,
  output rsnh_pkg::dp_cmd_t    cmd,
  input  rsnh_pkg::dp_status_t sts
);

  rsnh_pkg::state_t               state_r, state_nxt;
  logic [rsnh_pkg::CNT_W-1:0]     cnt_r, cnt_nxt;
  logic                           last_r, last_nxt;
  logic                           out_valid_r, out_valid_nxt;
  rsnh_pkg::state_t               fin_st;

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= rsnh_pkg::ST_IDLE;
      cnt_r       <= '0;
      last_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      last_r      <= last_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == rsnh_pkg::ST_IDLE);
  assign out_valid = out_valid_r;
  assign fin_st    = last_r ? rsnh_pkg::ST_ZONE : rsnh_pkg::ST_IDLE;

  // next state and datapath commands
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    last_nxt      = last_r;
    out_valid_nxt = out_valid_r && !out_ready;
    cmd.op        = rsnh_pkg::OP_NONE;
    cmd.idx       = cnt_r[1:0];
    unique case (state_r)
      rsnh_pkg::ST_IDLE: begin
        cnt_nxt = '0;
        if (in_valid) begin
          last_nxt = in_last;
          if (in_req_type == rsnh_pkg::REQ_RAY) begin
            cmd.op    = rsnh_pkg::OP_LOAD_RAY;
            state_nxt = in_last ? rsnh_pkg::ST_ZONE : rsnh_pkg::ST_IDLE;
          end else begin
            cmd.op = rsnh_pkg::OP_LOAD_TGT;
            if (sts.cand_ok) begin
              state_nxt = rsnh_pkg::ST_SUB;
            end else begin
              state_nxt = in_last ? rsnh_pkg::ST_ZONE : rsnh_pkg::ST_IDLE;
            end
          end
        end
      end
      rsnh_pkg::ST_SUB: begin
        cmd.op    = rsnh_pkg::OP_SUB;
        state_nxt = rsnh_pkg::ST_DOT;
      end
      rsnh_pkg::ST_DOT: begin
        cmd.op  = rsnh_pkg::OP_DOT;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == 5'd2) begin
          cnt_nxt   = '0;
          state_nxt = rsnh_pkg::ST_P;
        end
      end
      rsnh_pkg::ST_P: begin
        cmd.op    = rsnh_pkg::OP_P;
        state_nxt = rsnh_pkg::ST_V;
      end
      rsnh_pkg::ST_V: begin
        cmd.op  = rsnh_pkg::OP_V;
        cnt_nxt = cnt_r + 1'b1;
        if (sts.v_out) begin
          state_nxt = fin_st;
        end else if (cnt_r == 5'd2) begin
          cnt_nxt   = '0;
          state_nxt = rsnh_pkg::ST_SQ;
        end
      end
      rsnh_pkg::ST_SQ: begin
        cmd.op  = rsnh_pkg::OP_SQ;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == 5'd2) begin
          cnt_nxt   = '0;
          state_nxt = rsnh_pkg::ST_R2;
        end
      end
      rsnh_pkg::ST_R2: begin
        cmd.op    = rsnh_pkg::OP_R2;
        state_nxt = sts.r2_neg ? fin_st : rsnh_pkg::ST_ROOT;
      end
      rsnh_pkg::ST_ROOT: begin
        cmd.op  = rsnh_pkg::OP_ROOT;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == rsnh_pkg::CNT_W'(rsnh_pkg::ROOT_ITERS - 1)) begin
          cnt_nxt   = '0;
          state_nxt = rsnh_pkg::ST_T;
        end
      end
      rsnh_pkg::ST_T: begin
        cmd.op    = rsnh_pkg::OP_T;
        state_nxt = sts.t_bad ? fin_st : rsnh_pkg::ST_HP;
      end
      rsnh_pkg::ST_HP: begin
        cmd.op  = rsnh_pkg::OP_HP;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == 5'd2) begin
          cnt_nxt   = '0;
          state_nxt = rsnh_pkg::ST_COMMIT;
        end
      end
      rsnh_pkg::ST_COMMIT: begin
        cmd.op    = rsnh_pkg::OP_COMMIT;
        state_nxt = fin_st;
      end
      rsnh_pkg::ST_ZONE: begin
        // wait for the output register to free up
        if (!out_valid_r || out_ready) begin
          cmd.op        = rsnh_pkg::OP_OUT;
          out_valid_nxt = 1'b1;
          state_nxt     = rsnh_pkg::ST_IDLE;
        end
      end
      default: state_nxt = rsnh_pkg::ST_IDLE;
    endcase
  end

endmodule
`default_nettype wire

// ===== rtl/core/rsnh_dp.sv =====
// datapath: ray state, shared multiplier, square root and result registers
`timescale 1ns / 1ps
`default_nettype none
module rsnh_dp (
  input  wire                         clk,
  input  wire                         rst_n,
  input  wire                         cfg_we,
  input  wire                         cfg_addr,
  input  wire  [rsnh_pkg::CFG_W-1:0]  cfg_wdata,
  input  wire  signed [31:0]          in_pos_x,
  input  wire  signed [31:0]          in_pos_y,
  input  wire  signed [31:0]          in_pos_z,
  input  wire  signed [17:0]          in_dir_x,
  input  wire  signed [17:0]          in_dir_y,
  input  wire  signed [17:0]          in_dir_z,
  input  wire  [30:0]                 in_max_range,
  input  wire  [15:0]                 in_entity_id,
  input  rsnh_pkg::dp_cmd_t           cmd,
  output rsnh_pkg::dp_status_t        sts,
  output logic                        out_hit,
  output logic [15:0]                 out_victim,
  output logic [30:0]                 out_hit_distance,
  output logic signed [31:0]          out_hit_x,
  output logic signed [31:0]          out_hit_y,
  output logic signed [31:0]          out_hit_z,
  output logic [2:0]                  out_zone
);

  localparam int F = rsnh_pkg::FRAC_BITS;

  // configuration
  logic [rsnh_pkg::CFG_W-1:0] radius_r, height_r;

  // query state
  logic signed [31:0] org_r [3];
  logic signed [17:0] dir_r [3];
  logic [15:0]        shooter_r;
  logic [31:0]        nd_r;
  logic [15:0]        nv_r;
  logic signed [31:0] np_r [3];
  logic signed [31:0] vf_r [3];

  // candidate work registers
  logic signed [31:0] feet_r [3];
  logic [15:0]        id_r;
  logic signed [33:0] oc_r [3];
  logic signed [53:0] acc_r;
  logic signed [38:0] p_r;
  logic signed [21:0] v_r [3];
  logic [41:0]        rt_rem_r, rt_res_r, rt_bit_r;
  logic [31:0]        t_r;
  logic signed [31:0] hp_r [3];

  // result registers
  logic               o_hit_r;
  logic [15:0]        o_victim_r;
  logic [30:0]        o_dist_r;
  logic signed [31:0] o_x_r, o_y_r, o_z_r;
  logic [2:0]         o_zone_r;

  // shared multiplier
  logic signed [39:0] mul_a;
  logic signed [21:0] mul_b;
  logic signed [61:0] prod, prod_sh;
  logic signed [21:0] r_s;
  logic [1:0]         ix;

  assign ix  = cmd.idx;
  assign r_s = signed'({1'b0, radius_r});

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (cmd.op)
      rsnh_pkg::OP_DOT: begin
        mul_a = 40'(oc_r[ix]);
        mul_b = 22'(dir_r[ix]);
      end
      rsnh_pkg::OP_V: begin
        mul_a = 40'(p_r);
        mul_b = 22'(dir_r[ix]);
      end
      rsnh_pkg::OP_SQ: begin
        mul_a = 40'(v_r[ix]);
        mul_b = v_r[ix];
      end
      rsnh_pkg::OP_R2: begin
        mul_a = 40'(r_s);
        mul_b = r_s;
      end
      rsnh_pkg::OP_HP: begin
        mul_a = signed'({8'b0, t_r});
        mul_b = 22'(dir_r[ix]);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign prod    = mul_a * mul_b;
  assign prod_sh = prod >>> F;

  // closest approach component and radius check
  logic signed [41:0] v_full, r_ext;
  assign v_full = 42'(oc_r[ix]) + 42'(prod_sh);
  assign r_ext  = 42'(r_s);

  // projection p = floor(-dot / 2^F)
  logic signed [54:0] neg_dot, p_full;
  assign neg_dot = -(55'(acc_r));
  assign p_full  = neg_dot >>> F;

  // r^2 - |v|^2
  logic signed [54:0] rem_full;
  assign rem_full = 55'(prod) - 55'(acc_r);

  // one root step
  logic [41:0] rt_trial;
  assign rt_trial = rt_res_r + rt_bit_r;

  // t = p - h, or p + h when that is negative
  logic signed [40:0] h_s, t1, tsel;
  assign h_s  = signed'({20'b0, rt_res_r[20:0]});
  assign t1   = 41'(p_r) - h_s;
  assign tsel = (t1 < 0) ? (41'(p_r) + h_s) : t1;

  // hit point component
  logic signed [31:0] hp_q;
  assign hp_q = org_r[ix] + 32'(prod_sh);

  // status toward the sequencer
  always_comb begin
    sts.cand_ok = (in_entity_id != 16'd0) && (in_entity_id != shooter_r);
    sts.v_out   = (v_full > r_ext) || (v_full < -r_ext);
    sts.r2_neg  = rem_full < 0;
    sts.t_bad   = (tsel < 0) || (tsel > signed'({9'b0, nd_r}));
  end

  // body zone from stored hit point and foot position
  logic signed [32:0] rel, dx;
  logic signed [40:0] rel100, hs;
  logic signed [33:0] adx;
  logic               upper, right, wide;
  logic [2:0]         zone_c;

  always_comb begin
    rel    = 33'(np_r[2]) - 33'(vf_r[2]);
    dx     = 33'(np_r[0]) - 33'(vf_r[0]);
    rel100 = 41'(rel) * 41'sd100;
    hs     = signed'({20'b0, height_r});
    adx    = (dx < 0) ? -(34'(dx)) : 34'(dx);
    wide   = (37'(adx) * 37'sd5) > (37'sd1 <<< F);
    upper  = rel100 > hs * 41'sd25;
    right  = np_r[0] > vf_r[0];
    if (rel100 > hs * 41'sd85) begin
      zone_c = rsnh_pkg::ZONE_HEAD;
    end else if (rel100 > hs * 41'sd55) begin
      zone_c = rsnh_pkg::ZONE_CHEST;
    end else if (rel100 > hs * 41'sd40) begin
      zone_c = rsnh_pkg::ZONE_STOMACH;
    end else if (wide) begin
      if (upper) begin
        zone_c = right ? rsnh_pkg::ZONE_R_ARM : rsnh_pkg::ZONE_L_ARM;
      end else begin
        zone_c = right ? rsnh_pkg::ZONE_R_LEG : rsnh_pkg::ZONE_L_LEG;
      end
    end else begin
      zone_c = upper ? rsnh_pkg::ZONE_STOMACH : rsnh_pkg::ZONE_L_LEG;
    end
  end

  // configuration and query state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r  <= rsnh_pkg::RADIUS_RST;
      height_r  <= rsnh_pkg::HEIGHT_RST;
      shooter_r <= '0;
      nd_r      <= '0;
      nv_r      <= '0;
      for (int i = 0; i < 3; i++) begin
        org_r[i] <= '0;
        dir_r[i] <= '0;
        np_r[i]  <= '0;
        vf_r[i]  <= '0;
      end
    end else begin
      if (cfg_we) begin
        if (cfg_addr == rsnh_pkg::CFG_SPHERE_RADIUS) begin
          radius_r <= cfg_wdata;
        end else begin
          height_r <= cfg_wdata;
        end
      end
      if (cmd.op == rsnh_pkg::OP_LOAD_RAY) begin
        org_r[0]  <= in_pos_x;
        org_r[1]  <= in_pos_y;
        org_r[2]  <= in_pos_z;
        dir_r[0]  <= in_dir_x;
        dir_r[1]  <= in_dir_y;
        dir_r[2]  <= in_dir_z;
        shooter_r <= in_entity_id;
        nd_r      <= {1'b0, in_max_range};
        nv_r      <= '0;
        for (int i = 0; i < 3; i++) begin
          np_r[i] <= '0;
          vf_r[i] <= '0;
        end
      end
      if (cmd.op == rsnh_pkg::OP_COMMIT) begin
        nd_r <= t_r;
        nv_r <= id_r;
        for (int i = 0; i < 3; i++) begin
          np_r[i] <= hp_r[i];
          vf_r[i] <= feet_r[i];
        end
      end
    end
  end

  // candidate work registers
  always_ff @(posedge clk) begin
    unique case (cmd.op)
      rsnh_pkg::OP_LOAD_TGT: begin
        feet_r[0] <= in_pos_x;
        feet_r[1] <= in_pos_y;
        feet_r[2] <= in_pos_z;
        id_r      <= in_entity_id;
      end
      rsnh_pkg::OP_SUB: begin
        oc_r[0] <= 34'(org_r[0]) - 34'(feet_r[0]);
        oc_r[1] <= 34'(org_r[1]) - 34'(feet_r[1]);
        oc_r[2] <= 34'(org_r[2]) - 34'(feet_r[2])
                   - signed'({14'b0, height_r[rsnh_pkg::CFG_W-1:1]});
        acc_r   <= '0;
      end
      rsnh_pkg::OP_DOT: acc_r <= acc_r + 54'(prod);
      rsnh_pkg::OP_P: begin
        p_r   <= 39'(p_full);
        acc_r <= '0;
      end
      rsnh_pkg::OP_V:  v_r[ix] <= v_full[21:0];
      rsnh_pkg::OP_SQ: acc_r <= acc_r + 54'(prod);
      rsnh_pkg::OP_R2: begin
        rt_rem_r <= rem_full[41:0];
        rt_res_r <= '0;
        rt_bit_r <= 42'd1 << 40;
      end
      rsnh_pkg::OP_ROOT: begin
        if (rt_rem_r >= rt_trial) begin
          rt_rem_r <= rt_rem_r - rt_trial;
          rt_res_r <= (rt_res_r >> 1) + rt_bit_r;
        end else begin
          rt_res_r <= rt_res_r >> 1;
        end
        rt_bit_r <= rt_bit_r >> 2;
      end
      rsnh_pkg::OP_T:  t_r <= tsel[31:0];
      rsnh_pkg::OP_HP: hp_r[ix] <= hp_q;
      default: ;
    endcase
  end

  // result registers
  always_ff @(posedge clk) begin
    if (cmd.op == rsnh_pkg::OP_OUT) begin
      o_dist_r <= nd_r[30:0];
      if (nv_r != 16'd0) begin
        o_hit_r    <= 1'b1;
        o_victim_r <= nv_r;
        o_x_r      <= np_r[0];
        o_y_r      <= np_r[1];
        o_z_r      <= np_r[2];
        o_zone_r   <= zone_c;
      end else begin
        o_hit_r    <= 1'b0;
        o_victim_r <= '0;
        o_x_r      <= '0;
        o_y_r      <= '0;
        o_z_r      <= '0;
        o_zone_r   <= rsnh_pkg::ZONE_HEAD;
      end
    end
  end

  assign out_hit          = o_hit_r;
  assign out_victim       = o_victim_r;
  assign out_hit_distance = o_dist_r;
  assign out_hit_x        = o_x_r;
  assign out_hit_y        = o_y_r;
  assign out_hit_z        = o_z_r;
  assign out_zone         = o_zone_r;

endmodule
`default_nettype wire

// ===== rtl/core/ray_sphere_nearest_hit.sv =====
// top level: nearest ray / sphere hit over a stream of targets
//
// Input beats: a ray start (req_type 0) loads origin, unit direction, range
// and shooter id; target beats (req_type 1) give an id and foot position.
// A beat with last set produces one result beat: hit flag, victim, distance,
// hit point and body zone.
// A ray start or a skipped target (id zero or the shooter) runs no test steps.
// A tested target keeps the input closed while it runs through offset, dot
// product, projection, closest approach, radius check, squared distance,
// square root, distance, hit point and commit. The shared multiplier serves
// the dot product, closest approach, squared distance, square of the radius
// and hit point, and the square root unit resolves one result bit per cycle.
// A target rejected early leaves sooner. A beat with last set then loads the
// result into the output registers, which hold it with its valid flag. Input
// is taken again while a result waits; if the receiver stalls and a second
// result is due, the block holds until the first one is taken.
// Reset is synchronous, active low; it clears the ray state and loads the
// default radius (0.5 m) and body height (1.8 m).
// Configuration writes take effect at once; the user makes them only while
// idle, as the block itself does not enforce it.
`timescale 1ns / 1ps
`default_nettype none
module ray_sphere_nearest_hit (
  input  wire                         clk,
  input  wire                         rst_n,
  input  wire                         cfg_we,
  input  wire                         cfg_addr,
  input  wire  [rsnh_pkg::CFG_W-1:0]  cfg_wdata,
  input  wire                         in_valid,
  output logic                        in_ready,
  input  wire                         in_req_type,
  input  wire  signed [31:0]          in_pos_x,
  input  wire  signed [31:0]          in_pos_y,
  input  wire  signed [31:0]          in_pos_z,
  input  wire  signed [17:0]          in_dir_x,
  input  wire  signed [17:0]          in_dir_y,
  input  wire  signed [17:0]          in_dir_z,
  input  wire  [30:0]                 in_max_range,
  input  wire  [15:0]                 in_entity_id,
  input  wire                         in_last,
  output logic                        out_valid,
  input  wire                         out_ready,
  output logic                        out_hit,
  output logic [15:0]                 out_victim,
  output logic [30:0]                 out_hit_distance,
  output logic signed [31:0]          out_hit_x,
  output logic signed [31:0]          out_hit_y,
  output logic signed [31:0]          out_hit_z,
  output logic [2:0]                  out_zone
);

  rsnh_pkg::dp_cmd_t    cmd;
  rsnh_pkg::dp_status_t sts;

  // sequencer
  rsnh_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_req_type(in_req_type),
    .in_last    (in_last),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .cmd        (cmd),
    .sts        (sts)
  );

  // datapath
  rsnh_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_addr        (cfg_addr),
    .cfg_wdata       (cfg_wdata),
    .in_pos_x        (in_pos_x),
    .in_pos_y        (in_pos_y),
    .in_pos_z        (in_pos_z),
    .in_dir_x        (in_dir_x),
    .in_dir_y        (in_dir_y),
    .in_dir_z        (in_dir_z),
    .in_max_range    (in_max_range),
    .in_entity_id    (in_entity_id),
    .cmd             (cmd),
    .sts             (sts),
    .out_hit         (out_hit),
    .out_victim      (out_victim),
    .out_hit_distance(out_hit_distance),
    .out_hit_x       (out_hit_x),
    .out_hit_y       (out_hit_y),
    .out_hit_z       (out_hit_z),
    .out_zone        (out_zone)
  );

endmodule
`default_nettype wire

// ===== rtl/core/rsnh_checker.sv =====
// port-level checks for the nearest-hit block, bound to the top level
`timescale 1ns / 1ps
`default_nettype none
module rsnh_checker (
  input wire        clk,
  input wire        rst_n,
  input wire        out_valid,
  input wire        out_ready,
  input wire        out_hit,
  input wire [15:0] out_victim,
  input wire [2:0]  out_zone
);

  // no result beat right after reset
  a_rst_quiet: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // a stalled result beat stays
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // a miss reports no victim and the head code
  a_miss: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_hit |-> out_victim == 16'd0 && out_zone == rsnh_pkg::ZONE_HEAD)
    else $error("miss with victim or zone");

  // a hit always names a nonzero victim
  a_hit: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_hit |-> out_victim != 16'd0)
    else $error("hit without victim");

  // zone code stays in range
  a_zone: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_zone <= rsnh_pkg::ZONE_R_LEG)
    else $error("bad zone code");

endmodule

bind ray_sphere_nearest_hit rsnh_checker u_rsnh_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_hit   (out_hit),
  .out_victim(out_victim),
  .out_zone  (out_zone)
);
`default_nettype wire
